>>> sv/pq4fs_pkg.sv
package pq4fs_pkg;

    localparam int NUM_VECTORS = 32;
    localparam int VEC_W       = 5;
    localparam int ACC_W       = 16;
    localparam int SUM_W       = 17;
    localparam int LUT_ENTRIES = 16;
    localparam int CODE_BYTES  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int S_DATA_W    = 256;
    localparam int M_DATA_W    = 24;

    localparam logic [VEC_W-1:0] LAST_VEC = VEC_W'(NUM_VECTORS - 1);

    // one looked-up table byte per vector, plus the run marker
    typedef struct packed {
        logic [NUM_VECTORS-1:0][7:0] lut_bytes;
        logic                        last;
    } t_entry;

    // code byte that feeds vector v; bit 4 of v selects the high nibble
    function automatic logic [3:0] code_byte_idx(input logic [VEC_W-1:0] v);
        return {v[2:0], v[3]};
    endfunction

endpackage

>>> sv/pq4fs_front.sv
module pq4fs_front
    import pq4fs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tlast,
    output logic                o_valid,
    input  logic                i_ready,
    output t_entry              o_entry
);

    logic                                r_valid;
    t_entry                              r_entry;
    t_entry                              n_entry;
    logic [LUT_ENTRIES-1:0][7:0]         w_table;
    logic [CODE_BYTES-1:0][7:0]          w_codes;
    logic                                w_accept;

    assign w_table    = i_s_tdata[127:0];
    assign w_codes    = i_s_tdata[255:128];
    assign o_s_tready = !r_valid || i_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        logic [7:0] code;
        logic [3:0] nib;
        n_entry.last = i_s_tlast;
        for (int v = 0; v < NUM_VECTORS; v++) begin
            code = w_codes[code_byte_idx(VEC_W'(v))];
            nib  = (v >= NUM_VECTORS / 2) ? code[7:4] : code[3:0];
            n_entry.lut_bytes[v] = w_table[nib];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry <= n_entry;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

>>> sv/pq4fs_queue.sv
module pq4fs_queue
    import pq4fs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_entry,
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> sv/pq4fs_back.sv
module pq4fs_back
    import pq4fs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_entry              i_entry,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    logic [ACC_W-1:0] r_even [NUM_VECTORS];
    logic [ACC_W-1:0] r_odd  [NUM_VECTORS];
    logic [SUM_W-1:0] r_sum  [NUM_VECTORS];
    logic [ACC_W-1:0] n_even [NUM_VECTORS];
    logic [ACC_W-1:0] n_odd  [NUM_VECTORS];
    logic             r_parity;
    logic             r_busy;
    logic [VEC_W-1:0] r_cnt;
    logic             w_pop;
    logic             w_out_xfer;
    logic             w_out_done;

    assign w_out_xfer = r_busy && i_m_tready;
    assign w_out_done = w_out_xfer && (r_cnt == LAST_VEC);
    assign o_ready    = !i_entry.last || !r_busy || w_out_done;
    assign w_pop      = i_valid && o_ready;

    always_comb begin
        for (int v = 0; v < NUM_VECTORS; v++) begin
            n_even[v] = r_even[v];
            n_odd[v]  = r_odd[v];
            if (r_parity) begin
                n_odd[v] = r_odd[v] + ACC_W'(i_entry.lut_bytes[v]);
            end else begin
                n_even[v] = r_even[v] + ACC_W'(i_entry.lut_bytes[v]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
            for (int v = 0; v < NUM_VECTORS; v++) begin
                r_even[v] <= '0;
                r_odd[v]  <= '0;
            end
        end else if (w_pop) begin
            if (i_entry.last) begin
                r_parity <= 1'b0;
                for (int v = 0; v < NUM_VECTORS; v++) begin
                    r_even[v] <= '0;
                    r_odd[v]  <= '0;
                end
            end else begin
                r_parity <= !r_parity;
                for (int v = 0; v < NUM_VECTORS; v++) begin
                    r_even[v] <= n_even[v];
                    r_odd[v]  <= n_odd[v];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_entry.last) begin
            for (int v = 0; v < NUM_VECTORS; v++) begin
                r_sum[v] <= SUM_W'(n_even[v]) + SUM_W'(n_odd[v]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_pop && i_entry.last) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_out_done) begin
            r_busy <= 1'b0;
        end else if (w_out_xfer) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {{(M_DATA_W - SUM_W - VEC_W){1'b0}}, r_sum[r_cnt], r_cnt};
    assign o_m_tlast  = r_cnt == LAST_VEC;

    a_emit_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && !w_out_done) |=> (r_busy && r_cnt == $past(r_cnt) + 1'b1))
        else $error("result index did not advance");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_entry.last) |-> (!r_busy || w_out_done))
        else $error("new run snapshot while results pending");

    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_entry.last) |=> (!r_parity && r_busy && r_cnt == '0))
        else $error("run end did not restart state");

endmodule

>>> sv/pq4_fast_scan_accumulate_core.sv
// 4-bit PQ fast-scan accumulator for a block of 32 vectors. Each slave transfer is one
// sub-quantizer (16-byte table plus 16 code bytes, tlast on the final one of a run). A
// front stage does the 32 table lookups, a 4-deep queue holds the looked-up bytes, and
// the back end adds them into two 16-bit banks per vector. The transfer with tlast
// starts 32 master transfers (vectors 0..31, tlast on 31), one per cycle while tready
// is high; accumulation of the next run goes on during them, and only that run's tlast
// transfer waits until the last result of the previous run has been taken.
module pq4_fast_scan_accumulate_core
    import pq4fs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // table_low, table_high, code_bytes_low,
                                            // code_bytes_high
    input  logic                i_s_tlast,  // last_subq
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // vector_index, distance_sum, zero pad
    output logic                o_m_tlast   // last_vector
);

    logic   w_f_valid;
    logic   w_f_ready;
    t_entry w_f_entry;
    logic   w_q_valid;
    logic   w_q_ready;
    t_entry w_q_entry;

    pq4fs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_valid    (w_f_valid),
        .i_ready    (w_f_ready),
        .o_entry    (w_f_entry)
    );

    pq4fs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_entry (w_f_entry),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_entry (w_q_entry)
    );

    pq4fs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_entry    (w_q_entry),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

>>> test/pq4_fast_scan_accumulate_checker.sv
`timescale 1ns / 100ps

module pq4_fast_scan_accumulate_checker
    import pq4fs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // table_low, table_high, code_bytes_low,
                                            // code_bytes_high
    input  logic                i_s_tlast,  // last_subq
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,  // vector_index, distance_sum, zero pad
    input  logic                i_m_tlast,  // last_vector
    output int                  o_mismatches,
    output int                  o_pending
);

    typedef struct {
        logic [VEC_W-1:0] vec;
        logic [SUM_W-1:0] sum;
        logic             last;
    } t_dist_result;

    logic [ACC_W-1:0] even_bank [NUM_VECTORS];
    logic [ACC_W-1:0] odd_bank  [NUM_VECTORS];
    logic             odd_phase;
    t_dist_result     dist_expected[$];
    int               mismatch_cnt;

    initial begin
        mismatch_cnt = 0;
        o_mismatches = 0;
        o_pending    = 0;
        odd_phase    = 1'b0;
        foreach (even_bank[v]) begin
            even_bank[v] = '0;
            odd_bank[v]  = '0;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 50) begin
            $display("[%0t] scan check: %s", $time, what);
        end
    endtask

    task automatic clear_banks();
        foreach (even_bank[v]) begin
            even_bank[v] = '0;
            odd_bank[v]  = '0;
        end
        odd_phase = 1'b0;
    endtask

    task automatic accumulate_subq(input logic [S_DATA_W-1:0] d, input logic last);
        logic [127:0] lut;
        logic [127:0] codes;
        logic [7:0]   cb;
        logic [7:0]   lo_byte;
        logic [7:0]   hi_byte;
        int           base;
        t_dist_result r;
        lut   = d[127:0];
        codes = d[255:128];
        for (int b = 0; b < CODE_BYTES; b++) begin
            cb      = codes[8*b +: 8];
            base    = (b % 2 == 1) ? 8 + b / 2 : b / 2;
            lo_byte = lut[8*int'(cb[3:0]) +: 8];
            hi_byte = lut[8*int'(cb[7:4]) +: 8];
            if (odd_phase) begin
                odd_bank[base]      = odd_bank[base] + ACC_W'(lo_byte);
                odd_bank[base + 16] = odd_bank[base + 16] + ACC_W'(hi_byte);
            end else begin
                even_bank[base]      = even_bank[base] + ACC_W'(lo_byte);
                even_bank[base + 16] = even_bank[base + 16] + ACC_W'(hi_byte);
            end
        end
        odd_phase = ~odd_phase;
        if (last) begin
            for (int v = 0; v < NUM_VECTORS; v++) begin
                r.vec  = VEC_W'(v);
                r.sum  = SUM_W'(even_bank[v]) + SUM_W'(odd_bank[v]);
                r.last = (v == NUM_VECTORS - 1);
                dist_expected.push_back(r);
            end
            clear_banks();
        end
    endtask

    task automatic check_result(input logic [M_DATA_W-1:0] d, input logic last);
        t_dist_result want;
        logic [VEC_W-1:0] got_vec;
        logic [SUM_W-1:0] got_sum;
        got_vec = d[VEC_W-1:0];
        got_sum = d[VEC_W +: SUM_W];
        if (dist_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result vector %0d sum %0d",
                                      got_vec, got_sum));
        end else begin
            want = dist_expected.pop_front();
            if (got_vec !== want.vec) begin
                report_mismatch($sformatf("vector_index got %0d want %0d", got_vec, want.vec));
            end
            if (got_sum !== want.sum) begin
                report_mismatch($sformatf("vector %0d distance_sum got %0d want %0d",
                                          want.vec, got_sum, want.sum));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("vector %0d last_vector got %b want %b",
                                          want.vec, last, want.last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_banks();
            dist_expected.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result(i_m_tdata, i_m_tlast);
            end
            if (i_s_tvalid && i_s_tready) begin
                accumulate_subq(i_s_tdata, i_s_tlast);
            end
        end
        o_pending    = dist_expected.size();
        o_mismatches = mismatch_cnt;
    end

endmodule

>>> test/tb_pq4_fast_scan_accumulate_core.sv
`timescale 1ns / 100ps

module tb_pq4_fast_scan_accumulate_core;
    import pq4fs_pkg::*;

    localparam int ITEMS_PER_PHASE = 28;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    int                  mismatches;
    int                  pending;
    int                  src_idle_pct = 11;
    int                  snk_stall_pct = 64;

    pq4_fast_scan_accumulate_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    pq4_fast_scan_accumulate_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        forever begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_subq(input logic [63:0] tbl_lo, input logic [63:0] tbl_hi,
                             input logic [63:0] code_lo, input logic [63:0] code_hi,
                             input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {code_hi, code_lo, tbl_hi, tbl_lo};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic send_random_run(input int len);
        for (int i = 0; i < len; i++) begin
            send_subq(pick_word(), pick_word(), pick_word(), pick_word(), i == len - 1);
        end
    endtask

    function automatic int pick_run_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 1;
        if (r < 75) return 2 * $urandom_range(1, 6);
        if (r < 90) return 2 * $urandom_range(0, 6) + 1;
        return $urandom_range(13, 48);
    endfunction

    task automatic random_phase(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = pick_run_len();
            send_random_run(len);
            sent += len;
            if ($urandom_range(7) == 0) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero run of one
        send_subq('0, '0, '0, '0, 1'b1);
        // every nibble value, distinct table entries
        send_subq(64'h7766554433221100, 64'hFFEEDDCCBBAA9988,
                  64'h8796A5B4C3D2E1F0, 64'h0F1E2D3C4B5A6978, 1'b1);
        send_subq('1, '1, '1, '1, 1'b0);
        send_subq('1, '1, '1, '1, 1'b1);
        send_subq(pick_word(), pick_word(), '0, '0, 1'b0);
        send_subq(pick_word(), pick_word(), '1, '0, 1'b1);
        // odd-length run
        send_random_run(3);
        send_subq({8{8'h55}}, {8{8'hAA}}, {8{8'h55}}, {8{8'hAA}}, 1'b0);
        send_subq({8{8'hAA}}, {8{8'h55}}, {8{8'hAA}}, {8{8'h55}}, 1'b0);
        send_subq({8{8'h0F}}, {8{8'hF0}}, {8{8'h0F}}, {8{8'hF0}}, 1'b0);
        send_subq({8{8'hF0}}, {8{8'h0F}}, {8{8'hF0}}, {8{8'h0F}}, 1'b1);
        drain_results();

        // long run of 0xFF entries: the sum of the two banks needs bit 16
        for (int i = 0; i < 258; i++) begin
            send_subq('1, '1, {$urandom, $urandom}, {$urandom, $urandom}, i == 257);
        end
        drain_results();

        random_phase(ITEMS_PER_PHASE);

        src_idle_pct  = 64;
        snk_stall_pct = 11;
        random_phase(ITEMS_PER_PHASE);

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        random_phase(ITEMS_PER_PHASE);

        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
